// ----- rtl/rd_pkg.sv -----
// shared types and constants for the restoring divider pipeline
// no dependencies; used by rd_step, rd_out_fifo, restoring_divider_32, rd_result_checker and tb
package rd_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned TdataW  = 2 * DataW;
  localparam int unsigned NumSteps = DataW;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned CountW  = $clog2(FifoDepth + 1);

  // work carried from one step stage to the next
  typedef struct packed {
    logic             zero;  // dividend was zero, result forced to zero
    logic [DataW-1:0] den;   // divisor
    logic [DataW-1:0] num;   // dividend bits not yet consumed, msb first
    logic [DataW-1:0] quo;   // quotient bits so far
    logic [DataW-1:0] rem;   // partial remainder
  } rd_stage_t;

  // finished result, quotient in the low half
  typedef struct packed {
    logic [DataW-1:0] remainder;
    logic [DataW-1:0] quotient;
  } rd_result_t;

  // output buffer status seen by the top level
  typedef struct packed {
    logic [CountW-1:0] count;
    logic              full;
  } rd_fifo_stat_t;

endpackage

// ----- rtl/rd_step.sv -----
// one restoring division step followed by its pipeline register
// depends on rd_pkg
module rd_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  rd_pkg::rd_stage_t stage_i,
  output logic              valid_o,
  output rd_pkg::rd_stage_t stage_o
);

  logic [rd_pkg::DataW:0]   shifted;
  logic [rd_pkg::DataW:0]   diff;
  logic                     take;
  rd_pkg::rd_stage_t        stage_d;
  rd_pkg::rd_stage_t        stage_q;
  logic                     valid_q;

  always_comb begin
    // shift next dividend bit into the remainder, keep the carried-out bit
    shifted = {stage_i.rem, stage_i.num[rd_pkg::DataW-1]};
    diff    = shifted - {1'b0, stage_i.den};
    take    = (shifted >= {1'b0, stage_i.den});
    stage_d      = stage_i;
    stage_d.num  = {stage_i.num[rd_pkg::DataW-2:0], 1'b0};
    stage_d.quo  = {stage_i.quo[rd_pkg::DataW-2:0], take};
    stage_d.rem  = take ? diff[rd_pkg::DataW-1:0] : shifted[rd_pkg::DataW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ----- rtl/rd_out_fifo.sv -----
// two-entry output buffer that decouples the pipeline from the receiver
// depends on rd_pkg
module rd_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rd_pkg::rd_result_t    data_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output rd_pkg::rd_result_t    data_o,
  output rd_pkg::rd_fifo_stat_t stat_o
);

  rd_pkg::rd_result_t              mem_q [rd_pkg::FifoDepth];
  logic                            wr_ptr_q, wr_ptr_d;
  logic                            rd_ptr_q, rd_ptr_d;
  logic [rd_pkg::CountW-1:0]       count_q, count_d;
  logic                            do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + rd_pkg::CountW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - rd_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o      = (count_q != '0);
  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.full  = (count_q == rd_pkg::CountW'(rd_pkg::FifoDepth));

endmodule

// ----- rtl/restoring_divider_32.sv -----
// top level of the pipelined 32-bit unsigned restoring divider
// depends on rd_pkg, rd_step and rd_out_fifo
//
// usage:
//   s_axis carries one division per transfer: dividend and divisor.
//   m_axis returns one result per transfer: quotient and remainder,
//   in the order the divisions were taken.
//   the datapath is 32 step stages, one restoring step (a 33-bit
//   compare and subtract) per stage, followed by a two-entry output
//   buffer. a new division can enter every cycle while the buffer
//   is not full. throughput is one division per cycle while the buffer
//   is not full, set by the single step per stage; the whole pipeline
//   moves together on one enable.
//   a zero divisor gives an all-ones quotient and the dividend as
//   remainder; a zero dividend gives zero for both.
//   when the receiver stalls, results collect in the output buffer; once
//   it holds two results the pipeline freezes and s_axis_tready_o drops,
//   nothing is lost or repeated. tready depends only on registered state.
//   reset clears the valid bits of every stage and empties the buffer.
module restoring_divider_32 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input channel
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [rd_pkg::TdataW-1:0] s_axis_tdata_i,  // [31:0] dividend, [63:32] divisor
  // output channel
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [rd_pkg::TdataW-1:0] m_axis_tdata_o   // [31:0] quotient, [63:32] remainder
);

  // pipeline enable: whole pipe advances while the buffer has room
  logic                  pipe_en;
  rd_pkg::rd_fifo_stat_t fifo_stat;

  // stage chain, index 0 is the entry point
  logic              vld    [rd_pkg::NumSteps+1];
  rd_pkg::rd_stage_t stg    [rd_pkg::NumSteps+1];

  rd_pkg::rd_result_t res_push;
  rd_pkg::rd_result_t res_head;
  logic               push;

  assign pipe_en         = !fifo_stat.full;
  assign s_axis_tready_o = pipe_en;

  // entry: load operands, remainder and quotient start at zero
  always_comb begin
    vld[0]      = s_axis_tvalid_i;
    stg[0].den  = s_axis_tdata_i[rd_pkg::TdataW-1:rd_pkg::DataW];
    stg[0].num  = s_axis_tdata_i[rd_pkg::DataW-1:0];
    stg[0].zero = (s_axis_tdata_i[rd_pkg::DataW-1:0] == '0);
    stg[0].quo  = '0;
    stg[0].rem  = '0;
  end

  // one restoring step per stage
  for (genvar i = 0; i < rd_pkg::NumSteps; i++) begin : g_step
    rd_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (vld[i]),
      .stage_i (stg[i]),
      .valid_o (vld[i+1]),
      .stage_o (stg[i+1])
    );
  end

  // a zero dividend forces a zero result whatever the divisor
  always_comb begin
    res_push.quotient  = stg[rd_pkg::NumSteps].zero ? '0 : stg[rd_pkg::NumSteps].quo;
    res_push.remainder = stg[rd_pkg::NumSteps].zero ? '0 : stg[rd_pkg::NumSteps].rem;
  end

  assign push = pipe_en && vld[rd_pkg::NumSteps];

  rd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res_push),
    .pop_i   (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .data_o  (res_head),
    .stat_o  (fifo_stat)
  );

  assign m_axis_tdata_o = res_head;

  // buffer never overfills
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.count <= rd_pkg::CountW'(rd_pkg::FifoDepth))
    else $error("output buffer count out of range");

  // input is refused exactly when the buffer is full
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (fifo_stat.count != rd_pkg::CountW'(rd_pkg::FifoDepth)))
    else $error("tready does not follow buffer occupancy");

  // a frozen pipeline keeps its last stage
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pipe_en && vld[rd_pkg::NumSteps]) |=>
      (vld[rd_pkg::NumSteps] && $stable(stg[rd_pkg::NumSteps])))
    else $error("last stage changed during stall");

endmodule

// ----- sim/rd_result_checker.sv -----
`timescale 1ns / 100ps
// in-order result checker for the restoring divider: predicts quotient and remainder
// for every input transfer and compares each output transfer against the oldest one
// depends on rd_pkg for the data width and the result layout
module rd_result_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  input  logic                      s_tready_i,
  input  logic [rd_pkg::TdataW-1:0] s_tdata_i,   // [31:0] dividend, [63:32] divisor
  input  logic                      m_tvalid_i,
  input  logic                      m_tready_i,
  input  logic [rd_pkg::TdataW-1:0] m_tdata_i,   // [31:0] quotient, [63:32] remainder
  output int unsigned               fail_count_o,
  output int unsigned               pending_o
);

  rd_pkg::rd_result_t quo_rem_queue[$];

  // one restoring step per dividend bit, compare done at 33 bits
  function automatic rd_pkg::rd_result_t restoring_quo_rem(
      input logic [rd_pkg::DataW-1:0] dividend,
      input logic [rd_pkg::DataW-1:0] divisor);
    rd_pkg::rd_result_t res;
    logic [rd_pkg::DataW:0] shifted;
    res = '0;
    if (dividend != '0) begin
      for (int i = rd_pkg::DataW - 1; i >= 0; i--) begin
        shifted = {res.remainder, dividend[i]};
        if (shifted >= {1'b0, divisor}) begin
          res.remainder = shifted[rd_pkg::DataW-1:0] - divisor;
          res.quotient  = {res.quotient[rd_pkg::DataW-2:0], 1'b1};
        end else begin
          res.remainder = shifted[rd_pkg::DataW-1:0];
          res.quotient  = {res.quotient[rd_pkg::DataW-2:0], 1'b0};
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin : watch_channels
    rd_pkg::rd_result_t got;
    rd_pkg::rd_result_t want;
    int unsigned errs;
    errs = 0;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        quo_rem_queue.push_back(restoring_quo_rem(s_tdata_i[rd_pkg::DataW-1:0],
                                                  s_tdata_i[rd_pkg::TdataW-1:rd_pkg::DataW]));
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (quo_rem_queue.size() == 0) begin
          $error("result transfer with no division outstanding: %h", m_tdata_i);
          errs++;
        end else begin
          want = quo_rem_queue.pop_front();
          if (got.quotient !== want.quotient) begin
            $error("quotient mismatch: expected %h, actual %h", want.quotient, got.quotient);
            errs++;
          end
          if (got.remainder !== want.remainder) begin
            $error("remainder mismatch: expected %h, actual %h", want.remainder,
                   got.remainder);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= $unsigned(quo_rem_queue.size());
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// testbench top for restoring_divider_32: directed edge cases, then random divisions
// with random idling on both stream channels; checking lives in rd_result_checker
// depends on rd_pkg, restoring_divider_32 and rd_result_checker
module tb;

  // longest run of cycles without any transfer before we give up
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned NumRandom  = 900;
  // settle time after the last result, a bit more than the pipeline latency
  localparam int unsigned DrainCycles = 40;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [rd_pkg::TdataW-1:0] s_axis_tdata = '0;   // [31:0] dividend, [63:32] divisor
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [rd_pkg::TdataW-1:0] m_axis_tdata;        // [31:0] quotient, [63:32] remainder

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  // when set neither side idles
  logic calm = 1'b0;

  always #2 clk_i = ~clk_i;

  restoring_divider_32 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  rd_result_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver: back-pressure with a chance of about 38 percent, none during the calm stretch
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 38);
  end

  // watchdog on cycles where neither channel makes a transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // operand with a random number of significant bits, so short values show up often
  function automatic logic [31:0] random_bits();
    return $urandom() >> $urandom_range(31);
  endfunction

  // one division: optional idle cycles, then hold tvalid until the transfer happens;
  // tready hangs off registered state only, so the value at the falling edge is
  // the one the next rising edge sees
  task automatic send_division(input logic [31:0] dividend, input logic [31:0] divisor);
    logic ready_seen;
    while (!calm && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {divisor, dividend};
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready;
      @(posedge clk_i);
    end while (!ready_seen);
  endtask

  initial begin
    logic [31:0] dividend;
    logic [31:0] divisor;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero dividend, with zero, small and all-ones divisors
    send_division(32'h0000_0000, 32'h0000_0000);
    send_division(32'h0000_0000, 32'h0000_0005);
    send_division(32'h0000_0000, 32'hffff_ffff);
    // zero divisor: all-ones quotient, dividend comes back as remainder
    send_division(32'h0000_0005, 32'h0000_0000);
    send_division(32'hffff_ffff, 32'h0000_0000);
    send_division(32'h8000_0000, 32'h0000_0000);
    // extremes of both fields
    send_division(32'hffff_ffff, 32'h0000_0001);
    send_division(32'hffff_ffff, 32'hffff_ffff);
    send_division(32'h0000_0001, 32'hffff_ffff);
    send_division(32'h0000_0001, 32'h0000_0001);
    send_division(32'h8000_0000, 32'h0000_0001);
    send_division(32'hffff_ffff, 32'h0000_0002);
    // divisors with the top bit set, where the 33-bit compare matters, and 7fff_ffff
    send_division(32'h8000_0000, 32'h8000_0000);
    send_division(32'hffff_ffff, 32'h8000_0000);
    send_division(32'h7fff_ffff, 32'h8000_0000);
    send_division(32'hffff_ffff, 32'h8000_0001);
    send_division(32'hc000_0000, 32'hc000_0001);
    send_division(32'hfffffffe, 32'hffff_ffff);
    send_division(32'hffff_ffff, 32'h7fff_ffff);
    // ordinary values and dividend smaller than divisor
    send_division(32'h0000_0100, 32'h0000_0007);
    send_division(32'h0000_0007, 32'h0000_0100);
    send_division(32'ha5a5_a5a5, 32'h5a5a_5a5a);
    send_division(32'h1234_5678, 32'h0000_0001);

    for (int n = 0; n < NumRandom; n++) begin
      calm = (n >= 300) && (n < 450);
      dividend = (n % 3 == 0) ? $urandom() : random_bits();
      divisor  = random_bits();
      case ($urandom_range(9))
        0: divisor = '0;
        1: dividend = '0;
        2: divisor = $urandom() | 32'h8000_0000;
        3: divisor = dividend + $urandom_range(2);
        4: divisor = $urandom() >> $urandom_range(31, 24);
        5: begin
          dividend = $urandom();
          divisor  = $urandom();
        end
        default: ;
      endcase
      send_division(dividend, divisor);
    end
    s_axis_tvalid <= 1'b0;
    calm = 1'b0;

    // pending is registered in the checker, so wait for the next clock edge before looking at it
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rd_pkg.sv
rtl/rd_step.sv
rtl/rd_out_fifo.sv
rtl/restoring_divider_32.sv
sim/rd_result_checker.sv
sim/tb.sv
